// ===== src/rcdc_pkg.sv =====
// Shared constants, types and fingerprint tables for the content-defined chunker.
package rcdc_pkg;

   // Stream and window geometry
   localparam int WINDOW   = 32;
   localparam int SEG_BITS = 16;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int BYTE_W   = 8;
   localparam int PRINT_W  = 63;
   localparam int CFG_W    = 16;
   localparam int CMP_W    = (SEG_BITS > CFG_W) ? SEG_BITS : CFG_W;
   localparam int IDX_W    = 2;
   localparam int TAB_N    = 256;

   // Degree-63 field polynomial
   localparam logic [63:0] POLY = 64'hbfe6b8a5bf378d83;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_MIN = 2'd0;
   localparam logic [IDX_W-1:0] CSR_AVG = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAX = 2'd2;

   // Request commands
   localparam logic CMD_FEED  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Register reset values
   localparam logic [CFG_W-1:0] MIN_RST = 16'd2048;
   localparam logic [CFG_W-1:0] AVG_RST = 16'd8192;
   localparam logic [CFG_W-1:0] MAX_RST = 16'd65535;

   typedef logic [PRINT_W-1:0] print_type;
   typedef print_type tab_type [TAB_N];

   // Request as it leaves the window ring
   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] old_byte;
   } ring_out_type;

   // Segment limits as held by the register bank
   typedef struct packed {
      logic [CFG_W-1:0] min_size;
      logic [CFG_W-1:0] max_size;
      logic [CFG_W-1:0] mask;
   } cfg_type;

   // One result
   typedef struct packed {
      logic             boundary;
      print_type        fingerprint;
      logic [CFG_W-1:0] segment_length;
   } rsp_type;

   // Fingerprint mask: all ones below the top set bit of the average
   function automatic logic [CFG_W-1:0] avg_mask(input logic [CFG_W-1:0] avg);
      logic [CFG_W-1:0] m;
      m = '0;
      for (int i = 0; i < CFG_W; i++) begin
         m[i] = |(avg >> (i + 1));
      end
      return m;
   endfunction

   localparam logic [CFG_W-1:0] MASK_RST = avg_mask(AVG_RST);

   // Remainder of a 128-bit polynomial modulo POLY
   function automatic logic [63:0] gf_reduce(input logic [127:0] x);
      logic [127:0] r;
      r = x;
      for (int b = 127; b >= 63; b--) begin
         if (r[b]) begin
            r = r ^ ({64'd0, POLY} << (b - 63));
         end
      end
      return r[63:0];
   endfunction

   function automatic logic [63:0] gf_mulmod(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = p ^ ({64'd0, y} << i);
         end
      end
      return gf_reduce(p);
   endfunction

   // Append table, indexed by the byte shifted out of the top
   function automatic tab_type build_t();
      tab_type     t;
      logic [63:0] t1;
      logic [63:0] m;
      t1 = gf_reduce({64'd0, 64'h8000000000000000});
      for (int i = 0; i < TAB_N; i++) begin
         m    = gf_mulmod(64'(i), t1);
         t[i] = m[PRINT_W-1:0];
      end
      return t;
   endfunction

   localparam tab_type TAB_T = build_t();

   function automatic print_type push_byte(input print_type p, input logic [BYTE_W-1:0] b);
      return {p[PRINT_W-BYTE_W-1:0], b} ^ TAB_T[p[PRINT_W-1 -: BYTE_W]];
   endfunction

   // Removal table, indexed by the byte leaving the window
   function automatic tab_type build_u();
      tab_type     t;
      print_type   span;
      logic [63:0] m;
      span = print_type'(1);
      for (int i = 1; i < WINDOW; i++) begin
         span = push_byte(span, '0);
      end
      for (int i = 0; i < TAB_N; i++) begin
         m    = gf_mulmod(64'(i), {1'b0, span});
         t[i] = m[PRINT_W-1:0];
      end
      return t;
   endfunction

   localparam tab_type TAB_U = build_u();

endpackage

// ===== src/rcdc_if.sv =====
// Request and result channel interfaces of the chunker.
interface rcdc_req_if;
   import rcdc_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface rcdc_rsp_if;
   import rcdc_pkg::*;
   logic             valid;
   logic             ready;
   logic             boundary;
   print_type        fingerprint;
   logic [CFG_W-1:0] segment_length;
   modport source (output valid, output boundary, output fingerprint, output segment_length,
                   input ready);
   modport sink (input valid, input boundary, input fingerprint, input segment_length,
                 output ready);
endinterface

// ===== src/rcdc_ring.sv =====
// Window ring memory: stores each byte and reads back the byte it replaces.
module rcdc_ring (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        acc,
   input  logic                        cmd,
   input  logic [rcdc_pkg::BYTE_W-1:0] data_byte,
   input  logic                        take,
   output logic                        free,
   output rcdc_pkg::ring_out_type      s1
);
   import rcdc_pkg::*;

   logic [BYTE_W-1:0] ring_mem [WINDOW];
   logic [BYTE_W-1:0] rd_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              wrapped_ff, wrapped_in;
   logic              s1_v_ff;
   logic              cmd_ff;
   logic              old_ok_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_slot;

   assign free      = !s1_v_ff || take;
   assign last_slot = (slot_ff == SLOT_W'(WINDOW - 1));

   // Advance the write slot; a clear request restarts it and marks the ring empty
   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (acc) begin
         if (cmd == CMD_CLEAR) begin
            slot_in    = '0;
            wrapped_in = 1'b0;
         end else begin
            slot_in    = last_slot ? '0 : slot_ff + 1'b1;
            wrapped_in = wrapped_ff | last_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         s1_v_ff    <= 1'b0;
      end else begin
         slot_ff    <= slot_in;
         wrapped_ff <= wrapped_in;
         if (free) begin
            s1_v_ff <= acc;
         end
      end
   end

   // Hold the request beside the read data
   always_ff @(posedge clock) begin
      if (acc) begin
         cmd_ff    <= cmd;
         byte_ff   <= data_byte;
         old_ok_ff <= wrapped_ff;
      end
   end

   // Write the new byte; read the old one in the same cycle
   always_ff @(posedge clock) begin
      if (acc && cmd == CMD_FEED) begin
         ring_mem[slot_ff] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rd_ff <= ring_mem[slot_ff];
      end
   end

   // Slots not yet written since the last clear read as zero
   always_comb begin
      s1.valid     = s1_v_ff;
      s1.cmd       = cmd_ff;
      s1.data_byte = byte_ff;
      s1.old_byte  = old_ok_ff ? rd_ff : '0;
   end
endmodule

// ===== src/rcdc_roll.sv =====
// Rolling fingerprint, segment length and boundary decision with result register.
module rcdc_roll (
   input  logic                   clock,
   input  logic                   reset,
   input  rcdc_pkg::ring_out_type s1,
   input  rcdc_pkg::cfg_type      cfg,
   input  logic                   out_ready,
   output logic                   s2_free,
   output logic                   out_valid,
   output rcdc_pkg::rsp_type      out_data
);
   import rcdc_pkg::*;

   logic                s2_v_ff;
   logic                s2_cmd_ff;
   logic [BYTE_W-1:0]   s2_byte_ff;
   print_type           s2_u_ff;
   print_type           fp_ff, fp_in;
   logic [SEG_BITS-1:0] len_ff, len_in;
   logic                out_v_ff;
   rsp_type             out_ff, out_in;
   logic                out_adv;
   logic                s2_go;
   print_type           q;
   print_type           fp_new;
   logic [SEG_BITS-1:0] len_new;
   logic [CMP_W-1:0]    len_ext;
   logic                hit;

   assign out_adv   = !out_v_ff || out_ready;
   assign s2_free   = !s2_v_ff || out_adv;
   assign s2_go     = s2_v_ff && out_adv;
   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

   // Look up the removal term for the byte leaving the window
   always_ff @(posedge clock) begin
      if (s1.valid && s2_free) begin
         s2_cmd_ff  <= s1.cmd;
         s2_byte_ff <= s1.data_byte;
         s2_u_ff    <= TAB_U[s1.old_byte];
      end
   end

   // Remove the old byte, then shift in the new one
   always_comb begin
      q       = fp_ff ^ s2_u_ff;
      fp_new  = {q[PRINT_W-BYTE_W-1:0], s2_byte_ff} ^ TAB_T[q[PRINT_W-1 -: BYTE_W]];
      len_new = (&len_ff) ? len_ff : len_ff + 1'b1;
      len_ext = CMP_W'(len_new);
      hit     = (len_ext >= CMP_W'(cfg.min_size)) &&
                (((fp_new[CFG_W-1:0] & cfg.mask) == '0) || (len_ext == CMP_W'(cfg.max_size)));
   end

   // Update state and build the result
   always_comb begin
      fp_in  = fp_ff;
      len_in = len_ff;
      out_in = out_ff;
      if (s2_go) begin
         if (s2_cmd_ff == CMD_CLEAR) begin
            fp_in  = '0;
            len_in = '0;
            out_in = '0;
         end else begin
            fp_in                 = fp_new;
            len_in                = hit ? '0 : len_new;
            out_in.boundary       = hit;
            out_in.fingerprint    = fp_new;
            out_in.segment_length = len_ext[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         fp_ff    <= '0;
         len_ff   <= '0;
      end else begin
         if (s2_free) begin
            s2_v_ff <= s1.valid;
         end
         if (out_adv) begin
            out_v_ff <= s2_v_ff;
         end
         fp_ff  <= fp_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end
endmodule

// ===== src/rabin_content_defined_chunker.sv =====
// Top level of the Rabin content-defined chunker.
// A request is registered in the window ring stage, then in the removal lookup stage,
// then in the result register. Throughput: one byte per cycle while rsp_ch is ready;
// the fingerprint register feeds back through one append-table lookup, and the window
// ring memory is read and written once a cycle. Reset clears the pipeline, ring slot,
// fingerprint and length, sets the minimum to 2048, the maximum to 65535 and the mask
// to that of an 8192 average; ring contents need no clearing pass.
module rabin_content_defined_chunker (
   input  logic                       clock,
   input  logic                       reset,
   rcdc_req_if.sink                   req_ch,
   rcdc_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [rcdc_pkg::IDX_W-1:0] csr_index,
   input  logic [rcdc_pkg::CFG_W-1:0] csr_wdata
);
   import rcdc_pkg::*;

   logic [CFG_W-1:0] min_ff, min_in;
   logic [CFG_W-1:0] max_ff, max_in;
   logic [CFG_W-1:0] mask_ff, mask_in;
   cfg_type          cfg;
   ring_out_type     s1;
   rsp_type          out_data;
   logic             ring_free;
   logic             s2_free;
   logic             acc;

   // Decode register writes
   always_comb begin
      min_in  = min_ff;
      max_in  = max_ff;
      mask_in = mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN: min_in  = csr_wdata;
            CSR_AVG: mask_in = avg_mask(csr_wdata);
            CSR_MAX: max_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_RST;
         max_ff  <= MAX_RST;
         mask_ff <= MASK_RST;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         mask_ff <= mask_in;
      end
   end

   assign cfg.min_size = min_ff;
   assign cfg.max_size = max_ff;
   assign cfg.mask     = mask_ff;

   assign req_ch.ready = ring_free;
   assign acc          = req_ch.valid && ring_free;

   rcdc_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .cmd       (req_ch.cmd),
      .data_byte (req_ch.data_byte),
      .take      (s2_free),
      .free      (ring_free),
      .s1        (s1)
   );

   rcdc_roll u_roll (
      .clock     (clock),
      .reset     (reset),
      .s1        (s1),
      .cfg       (cfg),
      .out_ready (rsp_ch.ready),
      .s2_free   (s2_free),
      .out_valid (rsp_ch.valid),
      .out_data  (out_data)
   );

   assign rsp_ch.boundary       = out_data.boundary;
   assign rsp_ch.fingerprint    = out_data.fingerprint;
   assign rsp_ch.segment_length = out_data.segment_length;

   // A boundary never ends a segment shorter than the minimum
   a_min_len: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.boundary |-> rsp_ch.segment_length >= min_ff)
      else $error("boundary below minimum segment length");

   // Only a clear request reports zero length, and it reports no boundary
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.segment_length == '0 |-> !rsp_ch.boundary)
      else $error("boundary with zero segment length");

   // A clear result carries a zero fingerprint
   a_clear_fp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.segment_length == '0 |-> rsp_ch.fingerprint == '0)
      else $error("nonzero fingerprint on clear result");
endmodule
